FILE: design/nnis_pkg.sv
// Shared constants, register indexes and control/status types for the
// nearest neighbor integer scaler. No dependencies.
package nnis_pkg;

  localparam int PIX_W     = 24;
  localparam int COORD_W   = 15;
  localparam int SCALE_W   = 7;
  localparam int DIM_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  localparam int DEF_MAX_WIDTH   = 4096;
  localparam int DEF_MAX_HEIGHT  = 4096;
  localparam int DEF_MAX_ENLARGE = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SHRINK_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

  typedef struct packed {
    logic capture;   // take input word, restart block sequencer
    logic mul;       // register shrink bound products
    logic load_enl;  // load one replicated word, step sequencer
    logic load_shr;  // load the kept decimated word
    logic advance;   // move position counters to the next input
  } nnis_cmd_t;

  typedef struct packed {
    logic out_free;
    logic shrink;
    logic keep;
    logic enl_last;
  } nnis_sts_t;

endpackage

FILE: design/nnis_if.sv
// Valid/ready channels of the scaler: input pixel words and result words.
// Depends on nnis_pkg.
interface nnis_in_if import nnis_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_bgr;

  modport source (output valid, output pixel_bgr, input ready);
  modport sink   (input valid, input pixel_bgr, output ready);
endinterface

interface nnis_out_if import nnis_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   out_pixel;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic               last_of_burst;
  logic               frame_done;

  modport source (output valid, output out_pixel, output out_x, output out_y,
                  output last_of_burst, output frame_done, input ready);
  modport sink   (input valid, input out_pixel, input out_x, input out_y,
                  input last_of_burst, input frame_done, output ready);
endinterface

FILE: design/nnis_dp.sv
// Scaler datapath: configuration registers, position counters, block
// sequencer, shrink bound products and the output word register. Uses nnis_pkg.
module nnis_dp import nnis_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int MAX_ENLARGE = DEF_MAX_ENLARGE
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic [PIX_W-1:0]     in_pixel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_pixel,
  output logic [COORD_W-1:0]   out_x,
  output logic [COORD_W-1:0]   out_y,
  output logic                 out_last,
  output logic                 out_done,
  input  nnis_cmd_t            cmd,
  output nnis_sts_t            sts
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WE_W   = $clog2(MAX_WIDTH + 1);
  localparam int HE_W   = $clog2(MAX_HEIGHT + 1);
  localparam int SE_W   = $clog2(MAX_ENLARGE + 1);
  localparam int K_W    = $clog2(MAX_ENLARGE);
  localparam int PROD_W = COORD_W + 1 + SCALE_W;
  localparam int CMP_W  = PROD_W + 1;

  // configuration
  logic               shrink_r;
  logic [SCALE_W-1:0] scale_r;
  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;

  // position state
  logic [COL_W-1:0]   in_col_r, in_col_nxt;
  logic [ROW_W-1:0]   in_row_r, in_row_nxt;
  logic [SCALE_W-1:0] col_phase_r, col_phase_nxt;
  logic [SCALE_W-1:0] row_phase_r, row_phase_nxt;
  logic [COORD_W-1:0] ocb_r, ocb_nxt;
  logic [COORD_W-1:0] orb_r, orb_nxt;

  // per-word working registers
  logic [PIX_W-1:0]   pix_r;
  logic [K_W-1:0]     k_r, k_nxt;
  logic [K_W-1:0]     r_r, r_nxt;
  logic [PROD_W-1:0]  prod_c_r, prod_r_r;

  // output word register
  logic               out_valid_r;
  logic [PIX_W-1:0]   out_pixel_r;
  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic               out_last_r, out_done_r;

  logic [SCALE_W-1:0] s_eff;
  logic [SE_W-1:0]    se;
  logic [WE_W-1:0]    w_eff;
  logic [HE_W-1:0]    h_eff;
  logic               lastcol, lastrow;
  logic               k_end, r_end;
  logic [SCALE_W:0]   col_ph_inc, row_ph_inc;
  logic [COORD_W:0]   ocb_p1, orb_p1;
  logic [CMP_W-1:0]   c_hi, r_hi, w_ext, h_ext;
  logic               fit, past;
  logic               out_free;
  logic               load;

  always_comb begin
    s_eff = (scale_r == '0) ? SCALE_W'(1) : scale_r;
    if (32'(s_eff) > 32'(MAX_ENLARGE)) begin
      se = SE_W'(MAX_ENLARGE);
    end else begin
      se = SE_W'(s_eff);
    end
    if (width_r == '0) begin
      w_eff = WE_W'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WE_W'(MAX_WIDTH);
    end else begin
      w_eff = WE_W'(width_r);
    end
    if (height_r == '0) begin
      h_eff = HE_W'(1);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = HE_W'(MAX_HEIGHT);
    end else begin
      h_eff = HE_W'(height_r);
    end
  end

  assign lastcol = WE_W'(in_col_r) >= (w_eff - WE_W'(1));
  assign lastrow = HE_W'(in_row_r) >= (h_eff - HE_W'(1));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shrink_r <= 1'b0;
      scale_r  <= SCALE_W'(1);
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHRINK_MODE:  shrink_r <= cfg_wdata[0];
        CFG_SCALE:        scale_r  <= cfg_wdata[SCALE_W-1:0];
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
      endcase
    end
  end

  // shrink test: out base < floor(dim/s) <=> (base+1)*s <= dim,
  // last output column/row <=> (base+2)*s > dim
  assign ocb_p1 = {1'b0, ocb_r} + (COORD_W+1)'(1);
  assign orb_p1 = {1'b0, orb_r} + (COORD_W+1)'(1);
  assign c_hi   = CMP_W'(prod_c_r) + CMP_W'(s_eff);
  assign r_hi   = CMP_W'(prod_r_r) + CMP_W'(s_eff);
  assign w_ext  = CMP_W'(w_eff);
  assign h_ext  = CMP_W'(h_eff);
  assign fit    = (CMP_W'(prod_c_r) <= w_ext) && (CMP_W'(prod_r_r) <= h_ext);
  assign past   = (c_hi > w_ext) && (r_hi > h_ext);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix_r <= in_pixel;
    end
    if (cmd.mul) begin
      prod_c_r <= PROD_W'(ocb_p1) * PROD_W'(s_eff);
      prod_r_r <= PROD_W'(orb_p1) * PROD_W'(s_eff);
    end
  end

  // block sequencer: column offset outer, row offset inner
  assign k_end = (SE_W'(k_r) == se - SE_W'(1));
  assign r_end = (SE_W'(r_r) == se - SE_W'(1));

  always_comb begin
    k_nxt = k_r;
    r_nxt = r_r;
    if (cmd.capture) begin
      k_nxt = '0;
      r_nxt = '0;
    end else if (cmd.load_enl) begin
      if (r_end) begin
        r_nxt = '0;
        k_nxt = k_r + K_W'(1);
      end else begin
        r_nxt = r_r + K_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
      r_r <= '0;
    end else begin
      k_r <= k_nxt;
      r_r <= r_nxt;
    end
  end

  // position counters
  assign col_ph_inc = {1'b0, col_phase_r} + (SCALE_W+1)'(1);
  assign row_ph_inc = {1'b0, row_phase_r} + (SCALE_W+1)'(1);

  always_comb begin
    in_col_nxt    = in_col_r;
    in_row_nxt    = in_row_r;
    col_phase_nxt = col_phase_r;
    row_phase_nxt = row_phase_r;
    ocb_nxt       = ocb_r;
    orb_nxt       = orb_r;
    if (cmd.advance) begin
      if (lastcol) begin
        in_col_nxt    = '0;
        col_phase_nxt = '0;
        ocb_nxt       = '0;
        if (lastrow) begin
          in_row_nxt    = '0;
          row_phase_nxt = '0;
          orb_nxt       = '0;
        end else begin
          in_row_nxt = in_row_r + ROW_W'(1);
          if (!shrink_r) begin
            orb_nxt = orb_r + COORD_W'(se);
          end else if (row_ph_inc >= {1'b0, s_eff}) begin
            row_phase_nxt = '0;
            orb_nxt       = orb_r + COORD_W'(1);
          end else begin
            row_phase_nxt = row_ph_inc[SCALE_W-1:0];
          end
        end
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
        if (!shrink_r) begin
          ocb_nxt = ocb_r + COORD_W'(se);
        end else if (col_ph_inc >= {1'b0, s_eff}) begin
          col_phase_nxt = '0;
          ocb_nxt       = ocb_r + COORD_W'(1);
        end else begin
          col_phase_nxt = col_ph_inc[SCALE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r    <= '0;
      in_row_r    <= '0;
      col_phase_r <= '0;
      row_phase_r <= '0;
      ocb_r       <= '0;
      orb_r       <= '0;
    end else begin
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      col_phase_r <= col_phase_nxt;
      row_phase_r <= row_phase_nxt;
      ocb_r       <= ocb_nxt;
      orb_r       <= orb_nxt;
    end
  end

  // output word register
  assign out_free = !out_valid_r || out_ready;
  assign load     = cmd.load_enl || cmd.load_shr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_enl) begin
      out_pixel_r <= pix_r;
      out_x_r     <= ocb_r + COORD_W'(k_r);
      out_y_r     <= orb_r + COORD_W'(r_r);
      out_last_r  <= k_end && r_end;
      out_done_r  <= k_end && r_end && lastcol && lastrow;
    end else if (cmd.load_shr) begin
      out_pixel_r <= pix_r;
      out_x_r     <= ocb_r;
      out_y_r     <= orb_r;
      out_last_r  <= 1'b1;
      out_done_r  <= past;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_last  = out_last_r;
  assign out_done  = out_done_r;

  assign sts.out_free = out_free;
  assign sts.shrink   = shrink_r;
  assign sts.keep     = fit && (col_phase_r == '0) && (row_phase_r == '0);
  assign sts.enl_last = k_end && r_end;

  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> out_free)
    else $error("output word loaded over an untaken word");

  a_shr_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_shr |-> (col_phase_r == '0) && (row_phase_r == '0))
    else $error("decimated word kept off block origin");

  a_seq_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_enl |-> (SE_W'(k_r) < se) && (SE_W'(r_r) < se))
    else $error("block sequencer beyond scale");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_last_r)
    else $error("frame end flagged on a word that does not end its burst");

endmodule

FILE: design/nnis_ctrl.sv
// Scaler controller: sequences capture, shrink test and output loads per
// input word. Uses nnis_pkg command and status types.
module nnis_ctrl import nnis_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  nnis_sts_t sts,
  output nnis_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sts.shrink ? ST_MUL : ST_EMIT;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        // drop the word at once, or hold until the output register frees
        if (!sts.keep) begin
          cmd.advance = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.load_shr = 1'b1;
          cmd.advance  = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.load_enl = 1'b1;
          if (sts.enl_last) begin
            cmd.advance = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_adv_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |=> !cmd.advance)
    else $error("position advanced twice for one word");

  a_mul_then_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |=> (state_r == ST_EVAL) && !in_ready)
    else $error("shrink test skipped after products");

  a_no_capture_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !cmd.capture)
    else $error("word captured while previous word in flight");

endmodule

FILE: design/nearest_neighbor_integer_scaler_core.sv
// Nearest neighbor integer scaler, top level: controller plus datapath.
// Depends on nnis_pkg, nnis_if, nnis_ctrl, nnis_dp.
//
// Pixel words arrive in row-major order. In enlarge mode each input word
// yields a scale-by-scale block of result words (scale capped at
// MAX_ENLARGE), sent column offset outer, row offset inner, one per cycle
// while the output side takes them; an input word occupies the block
// until its last result word is loaded. In shrink mode an input word
// goes through capture, bound multiply and the shrink test, and yields at
// most one result. A finished result waits in the output register while
// the next input word is taken. Configuration is written through
// cfg_we/cfg_index/cfg_wdata and must only change while no word is in
// flight; counters wrap at the end of each frame.
module nearest_neighbor_integer_scaler_core import nnis_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int MAX_ENLARGE = DEF_MAX_ENLARGE
) (
  input  logic                 clk,
  input  logic                 rst_n,
  nnis_in_if.sink              in_chan,
  nnis_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  nnis_cmd_t cmd;
  nnis_sts_t sts;

  nnis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nnis_dp #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_ENLARGE (MAX_ENLARGE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_pixel  (in_chan.pixel_bgr),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_pixel (out_chan.out_pixel),
    .out_x     (out_chan.out_x),
    .out_y     (out_chan.out_y),
    .out_last  (out_chan.last_of_burst),
    .out_done  (out_chan.frame_done),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
